FILE: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // multiplier operand slice handled per pipeline stage
    localparam int MUL_CHUNK = 16;

    typedef struct packed {
        logic hit;
        logic degenerate;
    } t_flags;

endpackage

FILE: design/rsi_dly.sv
// ----------------------------------------------------------------------------
// rsi_dly
// Enabled delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module rsi_dly #(
    parameter int WD = 8,
    parameter int N  = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WD-1:0] i_d,
    output logic [WD-1:0] o_d
);

    logic [WD-1:0] r_d [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_d[i] <= r_d[i-1];
            end
        end
    end

    assign o_d = r_d[N-1];

endmodule

FILE: design/rsi_mul.sv
// ----------------------------------------------------------------------------
// rsi_mul
// Pipelined signed multiplier, one slice of operand B per stage.
// ----------------------------------------------------------------------------
module rsi_mul #(
    parameter int AW = 65,
    parameter int BW = 67,
    parameter int CH = rsi_pkg::MUL_CHUNK
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int NS = (BW + CH - 1) / CH;
    localparam int PW = AW + BW;
    localparam int BX = NS * CH;

    logic signed [AW-1:0] w_a   [NS];
    logic signed [AW-1:0] r_a   [NS];
    logic signed [BX-1:0] w_b   [NS];
    logic signed [BX-1:0] r_b   [NS];
    logic signed [PW-1:0] w_acc [NS];
    logic signed [PW-1:0] r_acc [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [CH-1:0]        w_ch;
        logic signed [CH:0]   w_cs;
        logic signed [AW+CH:0] w_pp;

        if (j == 0) begin : g_first
            assign w_a[0]   = i_a;
            assign w_b[0]   = BX'(i_b);
            assign w_acc[0] = '0;
        end else begin : g_next
            assign w_a[j]   = r_a[j-1];
            assign w_b[j]   = r_b[j-1];
            assign w_acc[j] = r_acc[j-1];
        end

        assign w_ch = w_b[j][j*CH +: CH];
        // top slice carries the sign of B
        assign w_cs = (j == NS - 1) ? $signed({w_ch[CH-1], w_ch}) : $signed({1'b0, w_ch});
        assign w_pp = w_a[j] * w_cs;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[j]   <= w_a[j];
                r_b[j]   <= w_b[j];
                r_acc[j] <= w_acc[j] + (PW'(w_pp) <<< (j * CH));
            end
        end
    end

    assign o_p = r_acc[NS-1];

endmodule

FILE: design/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
    parameter int RW = 67
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);

    logic [RW+1:0] w_rem  [RW];
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] w_root [RW];
    logic [RW-1:0] r_root [RW];
    logic [2*RW-1:0] w_rest [RW];
    logic [2*RW-1:0] r_rest [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic [RW+1:0] w_rem2;
        logic [RW+1:0] w_trial;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem[0]  = '0;
            assign w_root[0] = '0;
            assign w_rest[0] = i_rad;
        end else begin : g_next
            assign w_rem[j]  = r_rem[j-1];
            assign w_root[j] = r_root[j-1];
            assign w_rest[j] = r_rest[j-1];
        end

        assign w_rem2  = {w_rem[j][RW-1:0], w_rest[j][2*RW-1 -: 2]};
        assign w_trial = {w_root[j], 2'b01};
        assign w_ge    = (w_rem2 >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
                r_root[j] <= {w_root[j][RW-2:0], w_ge};
                r_rest[j] <= w_rest[j] << 2;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

FILE: design/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined floor division of a signed numerator by a positive divisor,
// saturated to a signed QW-bit result.
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int NW = 85,
    parameter int DW = 64,
    parameter int QW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic signed [QW-1:0] o_quo
);

    localparam int CW = ((NW > DW + QW - 1) ? NW : DW + QW - 1) + 1;

    logic          w_neg;
    logic [NW-1:0] w_mag;
    logic [CW-1:0] w_lim;
    logic          w_sat;

    logic          r_p_neg;
    logic          r_p_sat;
    logic [NW-1:0] r_p_mag;
    logic [DW-1:0] r_p_den;

    assign w_neg = i_num[NW-1];
    assign w_mag = w_neg ? NW'(-i_num) : NW'(i_num);
    assign w_lim = CW'(i_den) << (QW - 1);
    assign w_sat = w_neg ? (CW'(w_mag) > w_lim) : (CW'(w_mag) >= w_lim);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_neg <= w_neg;
            r_p_sat <= w_sat;
            r_p_mag <= w_mag;
            r_p_den <= i_den;
        end
    end

    logic [DW-1:0] w_rem [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] w_q   [QW];
    logic [QW-1:0] r_q   [QW];
    logic [QW-1:0] w_lo  [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [DW-1:0] w_den [QW];
    logic [DW-1:0] r_den [QW];
    logic          w_ng  [QW];
    logic          r_ng  [QW];
    logic          w_st  [QW];
    logic          r_st  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW:0] w_rem2;
        logic        w_ge;

        if (j == 0) begin : g_first
            assign w_rem[0] = DW'(r_p_mag >> QW);
            assign w_q[0]   = '0;
            assign w_lo[0]  = r_p_mag[QW-1:0];
            assign w_den[0] = r_p_den;
            assign w_ng[0]  = r_p_neg;
            assign w_st[0]  = r_p_sat;
        end else begin : g_next
            assign w_rem[j] = r_rem[j-1];
            assign w_q[j]   = r_q[j-1];
            assign w_lo[j]  = r_lo[j-1];
            assign w_den[j] = r_den[j-1];
            assign w_ng[j]  = r_ng[j-1];
            assign w_st[j]  = r_st[j-1];
        end

        assign w_rem2 = {w_rem[j], w_lo[j][QW-1]};
        assign w_ge   = (w_rem2 >= {1'b0, w_den[j]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? DW'(w_rem2 - {1'b0, w_den[j]}) : w_rem2[DW-1:0];
                r_q[j]   <= {w_q[j][QW-2:0], w_ge};
                r_lo[j]  <= w_lo[j] << 1;
                r_den[j] <= w_den[j];
                r_ng[j]  <= w_ng[j];
                r_st[j]  <= w_st[j];
            end
        end
    end

    logic [QW-1:0] w_up;
    logic [QW-1:0] w_res;
    logic [QW-1:0] r_res;

    // negative numerators round toward minus infinity
    assign w_up = r_q[QW-1] + QW'(|r_rem[QW-1]);

    always_comb begin
        if (r_st[QW-1]) begin
            w_res = r_ng[QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else if (r_ng[QW-1]) begin
            w_res = QW'(-w_up);
        end else begin
            w_res = r_q[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_res;
        end
    end

    assign o_quo = $signed(r_res);

endmodule

FILE: design/ray_sphere_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_top
// Ray/sphere intersection in fixed point: quadratic setup, discriminant,
// square root and two saturating divisions, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one ray and sphere per transfer.
// Output channel: o_valid / i_stall carry t_near, t_far, hit, degenerate.
// Throughput: one transfer per cycle on both sides while i_stall does not hold a valid result.
// Most of the pipeline depth lies in the bit-per-stage square root and the
// two quotient-bit-per-stage dividers.
// Reset clears every valid bit in flight; payload is not cleared.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised, so nothing is lost or repeated.
// A zero direction gives degenerate with zero parameters; a negative
// discriminant gives hit low with zero parameters.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  logic [COORD_WIDTH-2:0]        i_radius,
    input  logic signed [COORD_WIDTH-1:0] i_camera_x,
    input  logic signed [COORD_WIDTH-1:0] i_camera_y,
    input  logic signed [COORD_WIDTH-1:0] i_camera_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_t_near,
    output logic signed [COORD_WIDTH-1:0] o_t_far,
    output logic                          o_hit,
    output logic                          o_degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int HW  = 2 * W + 3;
    localparam int AW  = 2 * W;
    localparam int KW  = HW;
    localparam int CH  = rsi_pkg::MUL_CHUNK;
    localparam int NS  = (HW + CH - 1) / CH;
    localparam int QSW = 2 * HW + 1;
    localparam int NW  = HW + 2 + FRAC_BITS;
    localparam int FW  = $bits(rsi_pkg::t_flags);
    localparam int LAT = W + HW + NS + 8;

    logic en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic signed [W-1:0] w_cen [3];
    logic signed [W-1:0] w_cam [3];
    logic signed [W-1:0] w_dir [3];

    assign w_cen = '{i_center_x, i_center_y, i_center_z};
    assign w_cam = '{i_camera_x, i_camera_y, i_camera_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};

    // stage 1: offsets
    logic signed [DW-1:0] r_s1_d [3];
    logic signed [W-1:0]  r_s1_v [3];
    logic [W-2:0]         r_s1_r;

    // stage 2: products
    logic signed [DW+W-1:0] r_s2_dv [3];
    logic signed [2*W-1:0]  r_s2_vv [3];
    logic signed [2*DW-1:0] r_s2_dd [3];
    logic [2*W-3:0]         r_s2_rr;

    // stage 3: h, a, k
    logic signed [HW-1:0] r_s3_h;
    logic [AW-1:0]        r_s3_a;
    logic signed [KW-1:0] r_s3_k;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_d[i]  <= DW'(w_cam[i]) - DW'(w_cen[i]);
                r_s1_v[i]  <= w_dir[i];
                r_s2_dv[i] <= r_s1_d[i] * r_s1_v[i];
                r_s2_vv[i] <= r_s1_v[i] * r_s1_v[i];
                r_s2_dd[i] <= r_s1_d[i] * r_s1_d[i];
            end
            r_s1_r  <= i_radius;
            r_s2_rr <= r_s1_r * r_s1_r;
            r_s3_h  <= HW'(r_s2_dv[0]) + HW'(r_s2_dv[1]) + HW'(r_s2_dv[2]);
            r_s3_a  <= AW'(r_s2_vv[0]) + AW'(r_s2_vv[1]) + AW'(r_s2_vv[2]);
            r_s3_k  <= KW'(r_s2_dd[0]) + KW'(r_s2_dd[1]) + KW'(r_s2_dd[2])
                       - KW'($signed({1'b0, r_s2_rr}));
        end
    end

    // h*h and a*k
    logic signed [2*HW-1:0]    w_hh;
    logic signed [AW+KW:0]     w_ak;

    rsi_mul #(.AW(HW), .BW(HW), .CH(CH)) u_mul_hh (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s3_h),
        .i_b   (r_s3_h),
        .o_p   (w_hh)
    );

    rsi_mul #(.AW(AW + 1), .BW(KW), .CH(CH)) u_mul_ak (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   ($signed({1'b0, r_s3_a})),
        .i_b   (r_s3_k),
        .o_p   (w_ak)
    );

    logic [HW+AW:0] w_m_side;
    logic [HW+AW:0] w_m_dly;

    assign w_m_side = {r_s3_h, r_s3_a, (r_s3_a == '0)};

    rsi_dly #(.WD(HW + AW + 1), .N(NS)) u_dly_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_m_side),
        .o_d   (w_m_dly)
    );

    // discriminant stage
    logic signed [QSW-1:0] w_q;
    logic                  r_q_neg;
    logic [2*HW-1:0]       r_q_mag;
    logic signed [HW-1:0]  r_q_h;
    logic [AW-1:0]         r_q_a;
    logic                  r_q_deg;

    assign w_q = QSW'(w_hh) - QSW'(w_ak);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_neg <= w_q[QSW-1];
            r_q_mag <= w_q[QSW-1] ? '0 : w_q[2*HW-1:0];
            r_q_h   <= $signed(w_m_dly[HW+AW:AW+1]);
            r_q_a   <= w_m_dly[AW:1];
            r_q_deg <= w_m_dly[0];
        end
    end

    logic [HW-1:0] w_s;

    rsi_sqrt #(.RW(HW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_q_mag),
        .o_root (w_s)
    );

    rsi_pkg::t_flags w_q_flags;
    logic [HW+AW+FW-1:0] w_s_side;
    logic [HW+AW+FW-1:0] w_s_dly;

    assign w_q_flags.hit        = !r_q_deg && !r_q_neg;
    assign w_q_flags.degenerate = r_q_deg;
    assign w_s_side = {r_q_h, r_q_a, w_q_flags};

    rsi_dly #(.WD(HW + AW + FW), .N(HW)) u_dly_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_s_side),
        .o_d   (w_s_dly)
    );

    // numerators
    logic signed [HW+1:0] w_nh;
    logic signed [HW+1:0] w_sv;
    logic signed [NW-1:0] r_n_near;
    logic signed [NW-1:0] r_n_far;
    logic [AW-1:0]        r_n_a;
    rsi_pkg::t_flags      r_n_flags;

    assign w_nh = -(HW+2)'($signed(w_s_dly[HW+AW+FW-1:AW+FW]));
    assign w_sv = $signed({2'b00, w_s});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_near  <= NW'(w_nh - w_sv) <<< FRAC_BITS;
            r_n_far   <= NW'(w_nh + w_sv) <<< FRAC_BITS;
            r_n_a     <= w_s_dly[AW+FW-1:FW];
            r_n_flags <= w_s_dly[FW-1:0];
        end
    end

    logic signed [W-1:0] w_near;
    logic signed [W-1:0] w_far;

    rsi_div #(.NW(NW), .DW(AW), .QW(W)) u_div_near (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_near),
        .i_den (r_n_a),
        .o_quo (w_near)
    );

    rsi_div #(.NW(NW), .DW(AW), .QW(W)) u_div_far (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_far),
        .i_den (r_n_a),
        .o_quo (w_far)
    );

    rsi_pkg::t_flags w_d_flags;

    rsi_dly #(.WD(FW), .N(W + 2)) u_dly_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_n_flags),
        .o_d   (w_d_flags)
    );

    // output register
    logic signed [W-1:0] r_o_near;
    logic signed [W-1:0] r_o_far;
    rsi_pkg::t_flags     r_o_flags;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_near  <= w_d_flags.hit ? w_near : '0;
            r_o_far   <= w_d_flags.hit ? w_far : '0;
            r_o_flags <= w_d_flags;
        end
    end

    assign o_t_near     = r_o_near;
    assign o_t_far      = r_o_far;
    assign o_hit        = r_o_flags.hit;
    assign o_degenerate = r_o_flags.degenerate;

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_degenerate))
        else $error("hit and degenerate both set");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_t_near == '0 && o_t_far == '0))
        else $error("nonzero parameters without hit");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_t_near <= o_t_far))
        else $error("t_near above t_far");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule
